// ----- design/frids_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frids_pkg;

   localparam int IdentW = 32;
   localparam int PosW   = 6;
   localparam int CntW   = 7;

   localparam logic [CntW-1:0] SlotReset = 7'd64;

   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [IdentW-1:0] ident;
      logic [PosW-1:0]   position;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic              evicted_valid;
      logic [IdentW-1:0] evicted_ident;
      logic [CntW-1:0]   occupancy;
      logic              read_valid;
      logic [IdentW-1:0] read_ident;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic keep;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/frids_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frids_cell
   import frids_pkg::*;
#(
   parameter int DataBits = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [DataBits-1:0] key,
   input  wire logic [DataBits-1:0] prev_data,
   input  wire logic                prev_valid,
   output logic      [DataBits-1:0] data,
   output logic                     valid,
   output logic                     match
);

   logic [DataBits-1:0] data_ff, data_in;
   logic                valid_ff, valid_in;
   logic                match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         // take the neighbour's entry; cells past the slot limit drop out
         data_in  = prev_data;
         valid_in = prev_valid & ctrl.keep;
      end
   end

   assign match_in = valid_ff && (data_ff == key);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ----- design/fifo_recent_id_set.sv -----
// A transaction accepted in the idle or decide state has its fields registered,
// then the cell row registers its compare, then the decide state shifts the row
// and loads the output register. The next transaction is accepted in that decide
// state at the earliest. A result held at the output freezes the decide cycle; no
// transaction is accepted until it moves on.
// Reset (synchronous, active high) empties the set and sets the slot count to 64;
// a slot count write also empties the set.
`timescale 1ns / 1ps
`default_nettype none

module fifo_recent_id_set
   import frids_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int IDENT_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_type         req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_type              rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [CntW-1:0] csr_data
);

   localparam int StoreBits = (IDENT_BITS < IdentW) ? IDENT_BITS : IdentW;
   localparam logic [CntW-1:0] CapClip = (CAPACITY > 127) ? 7'd127 : 7'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_DECIDE  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CntW-1:0]      slot_ff, slot_in;
   logic [CntW-1:0]      held_ff, held_in;
   logic                 op_ff;
   logic [StoreBits-1:0] key_ff;
   logic [PosW-1:0]      pos_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [StoreBits-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_valid;
   logic [CAPACITY-1:0]  cell_match;
   cell_ctrl_type        cell_ctrl [CAPACITY];

   logic                 accept;
   logic                 out_free;
   logic                 csr_write;
   logic [CntW-1:0]      limit;
   logic                 hit;
   logic                 insert;
   logic                 full;
   logic                 shift_en;
   logic [StoreBits-1:0] ev_data;
   logic [StoreBits-1:0] rd_data;
   logic                 rd_valid;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_DECIDE) && out_free));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid && csr_ready;

   // saturate the slot count to the range the row can hold
   always_comb begin
      if (slot_ff == '0) begin
         limit = 7'd1;
      end else if (slot_ff > CapClip) begin
         limit = CapClip;
      end else begin
         limit = slot_ff;
      end
   end

   assign hit      = (op_ff == OP_ACCESS) && (|cell_match);
   assign insert   = (op_ff == OP_ACCESS) && !(|cell_match);
   assign full     = (held_ff == limit);
   assign shift_en = (state_ff == ST_DECIDE) && out_free && insert;
   assign rd_valid = (op_ff == OP_READ) && ({1'b0, pos_ff} < held_ff);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign cell_ctrl[g] = '{shift: shift_en, clear: csr_write,
                                 keep: (g < int'(limit))};
         if (g == 0) begin : g_head
            frids_cell #(.DataBits(StoreBits)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl[g]),
               .key        (key_ff),
               .prev_data  (key_ff),
               .prev_valid (1'b1),
               .data       (cell_data[g]),
               .valid      (cell_valid[g]),
               .match      (cell_match[g])
            );
         end else begin : g_body
            frids_cell #(.DataBits(StoreBits)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl[g]),
               .key        (key_ff),
               .prev_data  (cell_data[g-1]),
               .prev_valid (cell_valid[g-1]),
               .data       (cell_data[g]),
               .valid      (cell_valid[g]),
               .match      (cell_match[g])
            );
         end
      end
   endgenerate

   // pick the oldest entry and the read position out of the row
   always_comb begin
      ev_data = '0;
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == int'(limit) - 1) begin
            ev_data = ev_data | cell_data[i];
         end
         if (i == int'(pos_ff)) begin
            rd_data = rd_data | cell_data[i];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (insert && !full) begin
                  held_in = held_ff + 7'd1;
               end
               rsp_valid_in         = 1'b1;
               rsp_in.hit           = hit;
               rsp_in.evicted_valid = insert && full;
               rsp_in.evicted_ident = (insert && full) ? IdentW'(ev_data) : '0;
               rsp_in.occupancy     = held_in;
               rsp_in.read_valid    = rd_valid;
               rsp_in.read_ident    = rd_valid ? IdentW'(rd_data) : '0;
               state_in             = accept ? ST_COMPARE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         slot_in = csr_data;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= SlotReset;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the transaction fields for the compare and decide cycles
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff  <= req_data.operation;
         key_ff <= req_data.ident[StoreBits-1:0];
         pos_ff <= req_data.position;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_held_within_limit: assert property (@(posedge clock) disable iff (reset)
      held_ff <= limit)
      else $error("held count exceeds slot limit");

   a_head_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (held_ff != '0))
      else $error("first cell valid disagrees with held count");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted_valid))
      else $error("hit and eviction reported together");

   a_read_excludes_access: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |-> (!rsp_ff.hit && !rsp_ff.evicted_valid))
      else $error("read result carries access flags");

   a_decide_after_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |=> (state_ff == ST_DECIDE))
      else $error("compare not followed by decide");
`endif

endmodule

`default_nettype wire
